// File: rtl/sac_pkg.sv
// Shared types and codes for the SIM access client state machine.
package sac_pkg;

	localparam int CfgAddrW = 5;

	// connection states
	localparam logic [3:0] ST_NOTCONN       = 4'd0;
	localparam logic [3:0] ST_CONNECTING    = 4'd1;
	localparam logic [3:0] ST_DISCONNECTING = 4'd2;
	localparam logic [3:0] ST_WAITCARD      = 4'd3;
	localparam logic [3:0] ST_IDLE          = 4'd4;
	localparam logic [3:0] ST_PROC          = 4'd5;

	// event modes
	localparam logic [2:0] MODE_TICK       = 3'd0;
	localparam logic [2:0] MODE_CONNECT    = 3'd1;
	localparam logic [2:0] MODE_REQUEST    = 3'd2;
	localparam logic [2:0] MODE_SERVER     = 3'd3;
	localparam logic [2:0] MODE_DISCONNECT = 3'd4;

	// client request kinds
	localparam logic [3:0] REQ_ATR      = 4'd0;
	localparam logic [3:0] REQ_RESET    = 4'd2;
	localparam logic [3:0] REQ_POWEROFF = 4'd6;
	localparam logic [2:0] REQ_IDX_ATR     = 3'd0;
	localparam logic [2:0] REQ_IDX_POWERON = 3'd5;

	// server message kinds
	localparam logic [3:0] SRV_CONNECT_RESP    = 4'd0;
	localparam logic [3:0] SRV_DISCONNECT_RESP = 4'd1;
	localparam logic [3:0] SRV_DISCONNECT_IND  = 4'd2;
	localparam logic [3:0] SRV_APDU_RESP       = 4'd3;
	localparam logic [3:0] SRV_ATR_RESP        = 4'd4;
	localparam logic [3:0] SRV_POWEROFF_RESP   = 4'd5;
	localparam logic [3:0] SRV_POWERON_RESP    = 4'd6;
	localparam logic [3:0] SRV_RESET_RESP      = 4'd7;
	localparam logic [3:0] SRV_STATUS_RESP     = 4'd8;
	localparam logic [3:0] SRV_STATUS_IND      = 4'd9;
	localparam logic [3:0] SRV_ERROR_RESP      = 4'd10;
	localparam logic [3:0] SRV_SETTP_RESP      = 4'd11;

	// outgoing message kinds
	localparam logic [3:0] SEND_CONNECT    = 4'd0;
	localparam logic [3:0] SEND_DISCONNECT = 4'd1;
	localparam logic [3:0] SEND_REQ_BASE   = 4'd2;

	// connection status byte
	localparam logic [7:0] CONN_OK          = 8'd0;
	localparam logic [7:0] CONN_UNABLE      = 8'd1;
	localparam logic [7:0] CONN_SIZE_BAD    = 8'd2;
	localparam logic [7:0] CONN_SIZE_SMALL  = 8'd3;
	localparam logic [7:0] CONN_OK_ONGOING  = 8'd4;

	// card status byte
	localparam logic [7:0] CARD_RESET          = 8'd1;
	localparam logic [7:0] CARD_NOT_ACCESSIBLE = 8'd2;
	localparam logic [7:0] CARD_INSERTED       = 8'd4;
	localparam logic [7:0] CARD_RECOVERED      = 8'd5;

	localparam logic [3:0] RSP_PARAM_MISSING = 4'd8;

	// register indexes
	localparam logic [2:0] REG_DEFAULT_SIZE = 3'd0;
	localparam logic [2:0] REG_SIZE_LIMIT   = 3'd1;
	localparam logic [2:0] REG_REQ_TIMEOUT  = 3'd2;
	localparam logic [2:0] REG_REL_TIMEOUT  = 3'd3;
	localparam logic [2:0] REG_CONN_TIMEOUT = 3'd4;

	typedef struct packed {
		logic [15:0] default_msg_size;
		logic [15:0] msg_size_limit;
		logic [15:0] request_timeout;
		logic [15:0] release_timeout;
		logic [15:0] connect_timeout;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  msg_kind;
		logic        param_found;
		logic [7:0]  param_byte;
		logic [15:0] param_word;
		logic [2:0]  result_code;
		logic [15:0] param_length;
	} evt_t;

	typedef struct packed {
		logic [3:0]  conn_state;
		logic [7:0]  card_state;
		logic        send_valid;
		logic [3:0]  send_kind;
		logic [15:0] send_size;
		logic        rsp_valid;
		logic [2:0]  rsp_kind;
		logic [3:0]  rsp_status;
		logic [15:0] rsp_length;
		logic        not_permitted;
	} res_t;

endpackage

// File: rtl/sac_cfg_regs.sv
// APB register file holding message size and timeout settings.
module sac_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sac_pkg::CfgAddrW-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output sac_pkg::cfg_t                cfg
);
	import sac_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CfgAddrW-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_msg_size <= 16'd300;
			cfg_q.msg_size_limit   <= 16'd300;
			cfg_q.request_timeout  <= 16'd5;
			cfg_q.release_timeout  <= 16'd5;
			cfg_q.connect_timeout  <= 16'd5;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DEFAULT_SIZE: cfg_q.default_msg_size <= pwdata[15:0];
				REG_SIZE_LIMIT:   cfg_q.msg_size_limit   <= pwdata[15:0];
				REG_REQ_TIMEOUT:  cfg_q.request_timeout  <= pwdata[15:0];
				REG_REL_TIMEOUT:  cfg_q.release_timeout  <= pwdata[15:0];
				REG_CONN_TIMEOUT: cfg_q.connect_timeout  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DEFAULT_SIZE: prdata = {16'd0, cfg_q.default_msg_size};
			REG_SIZE_LIMIT:   prdata = {16'd0, cfg_q.msg_size_limit};
			REG_REQ_TIMEOUT:  prdata = {16'd0, cfg_q.request_timeout};
			REG_REL_TIMEOUT:  prdata = {16'd0, cfg_q.release_timeout};
			REG_CONN_TIMEOUT: prdata = {16'd0, cfg_q.connect_timeout};
			default:          prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/sac_fsm.sv
// Connection state, card status, size and timer registers with per-event next-state logic.
module sac_fsm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  sac_pkg::evt_t evt,
	input  sac_pkg::cfg_t cfg,
	output sac_pkg::res_t res
);
	import sac_pkg::*;

	logic [3:0]  state_q, st_n;
	logic [7:0]  card_q, card_n;
	logic [15:0] size_q, size_n;
	logic [15:0] cnt_q, cnt_n;
	logic        armed_q, armed_n;

	logic        active;
	logic [2:0]  req_idx;
	logic [2:0]  rsp_idx;
	logic        rsp_has_param;
	logic        req_ok;

	assign active  = state_q >= ST_WAITCARD;
	assign req_idx = evt.msg_kind[2:0];

	always_comb begin
		rsp_idx       = 3'd4;
		rsp_has_param = 1'b0;
		unique case (evt.msg_kind)
			SRV_APDU_RESP:     begin rsp_idx = 3'd1; rsp_has_param = 1'b1; end
			SRV_ATR_RESP:      begin rsp_idx = 3'd0; rsp_has_param = 1'b1; end
			SRV_POWEROFF_RESP: rsp_idx = 3'd6;
			SRV_POWERON_RESP:  rsp_idx = 3'd5;
			SRV_RESET_RESP:    rsp_idx = 3'd2;
			SRV_STATUS_RESP:   begin rsp_idx = 3'd3; rsp_has_param = 1'b1; end
			default: ;
		endcase
	end

	// requests allowed while another one is in progress
	always_comb begin
		req_ok = 1'b0;
		if (evt.msg_kind == REQ_RESET) begin
			req_ok = (state_q == ST_PROC) || (state_q == ST_PROC + 4'd1) ||
				(state_q == ST_PROC + 4'd3);
		end else if (evt.msg_kind == REQ_POWEROFF) begin
			req_ok = (state_q == ST_PROC) || (state_q == ST_PROC + 4'd1) ||
				(state_q == ST_PROC + 4'd2) || (state_q == ST_PROC + 4'd3) ||
				(state_q == ST_PROC + 4'd5);
		end
	end

	always_comb begin
		st_n    = state_q;
		card_n  = card_q;
		size_n  = size_q;
		cnt_n   = cnt_q;
		armed_n = armed_q;
		res     = '0;

		unique case (evt.mode)
			MODE_TICK: begin
				if (armed_q) begin
					if (cnt_q <= 16'd1) begin
						armed_n = 1'b0;
						cnt_n   = 16'd0;
						if (state_q == ST_CONNECTING || state_q == ST_DISCONNECTING) begin
							st_n   = ST_NOTCONN;
							card_n = CARD_NOT_ACCESSIBLE;
							size_n = cfg.default_msg_size;
						end else if (state_q >= ST_PROC) begin
							st_n = ST_IDLE;
						end
					end else begin
						cnt_n = cnt_q - 16'd1;
					end
				end
			end
			MODE_CONNECT: begin
				if (state_q == ST_NOTCONN) begin
					st_n           = ST_CONNECTING;
					armed_n        = 1'b1;
					cnt_n          = cfg.connect_timeout;
					res.send_valid = 1'b1;
					res.send_kind  = SEND_CONNECT;
					res.send_size  = size_q;
				end else begin
					res.not_permitted = 1'b1;
				end
			end
			MODE_REQUEST: begin
				if (evt.msg_kind > REQ_POWEROFF) begin
					res.not_permitted = 1'b1;
				end else if (state_q == ST_IDLE || req_ok) begin
					st_n           = ST_PROC + {1'b0, req_idx};
					armed_n        = 1'b1;
					cnt_n          = cfg.request_timeout;
					res.send_valid = 1'b1;
					res.send_kind  = SEND_REQ_BASE + {1'b0, req_idx};
				end else begin
					res.not_permitted = 1'b1;
				end
			end
			MODE_SERVER: begin
				unique case (evt.msg_kind)
					SRV_CONNECT_RESP: begin
						if (state_q != ST_CONNECTING) begin
							res.not_permitted = 1'b1;
						end else if (!evt.param_found || evt.param_byte == CONN_UNABLE ||
								evt.param_byte == CONN_SIZE_SMALL ||
								(evt.param_byte == CONN_SIZE_BAD &&
								evt.param_word > cfg.msg_size_limit)) begin
							st_n    = ST_NOTCONN;
							armed_n = 1'b0;
							cnt_n   = 16'd0;
							card_n  = CARD_NOT_ACCESSIBLE;
							size_n  = cfg.default_msg_size;
						end else if (evt.param_byte == CONN_OK ||
								evt.param_byte == CONN_OK_ONGOING) begin
							st_n    = ST_WAITCARD;
							armed_n = 1'b0;
							cnt_n   = 16'd0;
							if (evt.param_byte == CONN_OK_ONGOING)
								card_n = CARD_NOT_ACCESSIBLE;
						end else if (evt.param_byte == CONN_SIZE_BAD) begin
							size_n         = evt.param_word;
							res.send_valid = 1'b1;
							res.send_kind  = SEND_CONNECT;
							res.send_size  = evt.param_word;
						end
					end
					SRV_DISCONNECT_RESP: begin
						if (state_q == ST_DISCONNECTING) begin
							st_n    = ST_NOTCONN;
							armed_n = 1'b0;
							cnt_n   = 16'd0;
							card_n  = CARD_NOT_ACCESSIBLE;
							size_n  = cfg.default_msg_size;
						end else begin
							res.not_permitted = 1'b1;
						end
					end
					SRV_DISCONNECT_IND: begin
						if (active) begin
							st_n           = ST_DISCONNECTING;
							armed_n        = 1'b1;
							cnt_n          = cfg.release_timeout;
							res.send_valid = 1'b1;
							res.send_kind  = SEND_DISCONNECT;
						end else begin
							res.not_permitted = 1'b1;
						end
					end
					SRV_STATUS_IND: begin
						if (!active) begin
							res.not_permitted = 1'b1;
						end else if (evt.param_found) begin
							card_n = evt.param_byte;
							if (evt.param_byte == CARD_RESET ||
									evt.param_byte == CARD_RECOVERED ||
									evt.param_byte == CARD_INSERTED) begin
								if (state_q != ST_IDLE) begin
									st_n    = ST_IDLE;
									armed_n = 1'b0;
									cnt_n   = 16'd0;
									if (state_q == ST_WAITCARD &&
											evt.param_byte == CARD_RESET) begin
										st_n           = ST_PROC + {1'b0, REQ_IDX_ATR};
										armed_n        = 1'b1;
										cnt_n          = cfg.request_timeout;
										res.send_valid = 1'b1;
										res.send_kind  = SEND_REQ_BASE + {1'b0, REQ_IDX_ATR};
									end
								end
								if (evt.param_byte == CARD_INSERTED) begin
									st_n           = ST_PROC + {1'b0, REQ_IDX_POWERON};
									armed_n        = 1'b1;
									cnt_n          = cfg.request_timeout;
									res.send_valid = 1'b1;
									res.send_kind  = SEND_REQ_BASE + {1'b0, REQ_IDX_POWERON};
								end
							end else if (state_q != ST_WAITCARD) begin
								st_n    = ST_WAITCARD;
								armed_n = 1'b0;
								cnt_n   = 16'd0;
							end
						end
					end
					SRV_ERROR_RESP: begin
						if (state_q == ST_CONNECTING) begin
							st_n    = ST_NOTCONN;
							armed_n = 1'b0;
							cnt_n   = 16'd0;
							card_n  = CARD_NOT_ACCESSIBLE;
							size_n  = cfg.default_msg_size;
						end else if (state_q > ST_IDLE) begin
							st_n    = ST_IDLE;
							armed_n = 1'b0;
							cnt_n   = 16'd0;
						end else begin
							res.not_permitted = 1'b1;
						end
					end
					SRV_APDU_RESP, SRV_ATR_RESP, SRV_POWEROFF_RESP, SRV_POWERON_RESP,
					SRV_RESET_RESP, SRV_STATUS_RESP, SRV_SETTP_RESP: begin
						if (state_q != ST_PROC + {1'b0, rsp_idx}) begin
							res.not_permitted = 1'b1;
						end else begin
							st_n          = ST_IDLE;
							armed_n       = 1'b0;
							cnt_n         = 16'd0;
							res.rsp_valid = 1'b1;
							res.rsp_kind  = rsp_idx;
							if (evt.result_code != 3'd0)
								res.rsp_status = {1'b0, evt.result_code};
							else if (rsp_has_param && !evt.param_found)
								res.rsp_status = RSP_PARAM_MISSING;
							else if (rsp_has_param)
								res.rsp_length = evt.param_length;
						end
					end
					default: res.not_permitted = 1'b1;
				endcase
			end
			MODE_DISCONNECT: begin
				if (active) begin
					st_n           = ST_DISCONNECTING;
					armed_n        = 1'b1;
					cnt_n          = cfg.release_timeout;
					res.send_valid = 1'b1;
					res.send_kind  = SEND_DISCONNECT;
				end else begin
					st_n    = ST_NOTCONN;
					armed_n = 1'b0;
					cnt_n   = 16'd0;
					card_n  = CARD_NOT_ACCESSIBLE;
					size_n  = cfg.default_msg_size;
				end
			end
			default: res.not_permitted = 1'b1;
		endcase

		res.conn_state = st_n;
		res.card_state = card_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_NOTCONN;
			card_q  <= CARD_NOT_ACCESSIBLE;
			size_q  <= 16'd300;
			cnt_q   <= 16'd0;
			armed_q <= 1'b0;
		end else if (step) begin
			state_q <= st_n;
			card_q  <= card_n;
			size_q  <= size_n;
			cnt_q   <= cnt_n;
			armed_q <= armed_n;
		end
	end

endmodule

// File: rtl/sim_access_client_fsm.sv
// Top level of the SIM access client state machine: input register, event logic, result register.
// One event is taken per clock while in_stall is low; its result passes the input register, then
// the result register, and the block sustains one event per cycle unless out_stall holds it, with
// combinational next-state logic between those two registers. A stalled result holds the result
// register and, once the input register is also full, raises in_stall in the same cycle. The user
// must write settings over the APB port only while no event is in flight; the block does not
// enforce this. Reads return the stored value. There is no clearing pass after reset.
module sim_access_client_fsm (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sac_pkg::CfgAddrW-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   mode,
	input  logic [3:0]                   msg_kind,
	input  logic                         param_found,
	input  logic [7:0]                   param_byte,
	input  logic [15:0]                  param_word,
	input  logic [2:0]                   result_code,
	input  logic [15:0]                  param_length,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [3:0]                   conn_state,
	output logic [7:0]                   card_state,
	output logic                         send_valid,
	output logic [3:0]                   send_kind,
	output logic [15:0]                  send_size,
	output logic                         rsp_valid,
	output logic [2:0]                   rsp_kind,
	output logic [3:0]                   rsp_status,
	output logic [15:0]                  rsp_length,
	output logic                         not_permitted
);
	import sac_pkg::*;

	cfg_t cfg;
	evt_t evt_s1;
	logic valid_s1;
	res_t res_next;
	res_t res_s2;
	logic valid_s2;
	logic advance;

	sac_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			evt_s1 <= '{mode: mode, msg_kind: msg_kind, param_found: param_found,
				param_byte: param_byte, param_word: param_word,
				result_code: result_code, param_length: param_length};
		end
	end

	sac_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.evt    (evt_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid     = valid_s2;
	assign conn_state    = res_s2.conn_state;
	assign card_state    = res_s2.card_state;
	assign send_valid    = res_s2.send_valid;
	assign send_kind     = res_s2.send_kind;
	assign send_size     = res_s2.send_size;
	assign rsp_valid     = res_s2.rsp_valid;
	assign rsp_kind      = res_s2.rsp_kind;
	assign rsp_status    = res_s2.rsp_status;
	assign rsp_length    = res_s2.rsp_length;
	assign not_permitted = res_s2.not_permitted;

	a_rsp_no_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rsp_valid |-> !send_valid)
		else $error("response report together with outgoing message");

	a_np_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_permitted |-> !send_valid && !rsp_valid)
		else $error("rejected event produced a message or report");

	a_notconn_card: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && conn_state == ST_NOTCONN |-> card_state == CARD_NOT_ACCESSIBLE)
		else $error("card status not reset in not-connected state");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> valid_s2 && $stable(res_s2))
		else $error("stalled result register changed");

endmodule
